>>> hdl/ksq_pkg.sv
// Shared types, codes and widths for the key extract stack queue.
package ksq_pkg;

  // Default sizes
  localparam int DEPTH_DEF      = 16;
  localparam int MAKER_BITS_DEF = 16;

  // Fixed field widths
  localparam int ID_W     = 31;
  localparam int SERIES_W = 32;
  localparam int MAKER_W  = 16;
  localparam int FILL_W   = 5;

  // Stream widths
  localparam int S_TDATA_W = 112;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 88;
  localparam int M_TUSER_W = 3;

  // Command codes
  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_EXTRACT    = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  // Per-cycle operation broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_SHR     = 3'd1,
    CELL_TAIL    = 3'd2,
    CELL_SHL     = 3'd3,
    CELL_CMP     = 3'd4,
    CELL_EXTRACT = 3'd5
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

endpackage

>>> hdl/key_extract_stack_queue_core.sv
// Top level of the key extract stack queue: command decode, cell chain, result register.
//
//  channel | dir | handshake           | contents
//  s_*     | in  | s_tvalid / s_tready | tuser: command; tdata: entry and search key
//  m_*     | out | m_tvalid / m_tready | tuser: found, status; tdata: record, fill
//
// Push front, push back and pop front register their result at the accept edge.
// Extract registers each cell's compare of its id with the key at the accept edge;
// the first-hit chain and the left shift finish in the search state.
// Reset empties the store at once; the records themselves are not cleared.
// The input is taken whenever no extract is in progress and the result register is
// empty or being read in the same cycle.
module key_extract_stack_queue_core #(
  parameter int DEPTH      = ksq_pkg::DEPTH_DEF,
  parameter int MAKER_BITS = ksq_pkg::MAKER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [30:0] entry_id, [62:31] entry_series, [78:63] entry_maker, [109:79] search_id
  input  logic [ksq_pkg::S_TDATA_W-1:0]   s_tdata,
  // [1:0] command
  input  logic [ksq_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [30:0] out_id, [62:31] out_series, [78:63] out_maker, [83:79] fill_level
  output logic [ksq_pkg::M_TDATA_W-1:0]   m_tdata,
  // [0] found, [2:1] status
  output logic [ksq_pkg::M_TUSER_W-1:0]   m_tuser
);
  import ksq_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_SEARCH = 2'b10
  } state_t;

  state_t           state, state_next;
  logic [CntW-1:0]  count, count_next;
  cell_ctrl_t       ctrl;

  // Input fields
  cmd_t                  cmd;
  logic [ID_W-1:0]       in_id;
  logic [SERIES_W-1:0]   in_series;
  logic [MAKER_W-1:0]    in_maker_raw;
  logic [MAKER_BITS-1:0] in_maker;
  logic [ID_W-1:0]       key;

  assign cmd          = cmd_t'(s_tuser[1:0]);
  assign in_id        = s_tdata[30:0];
  assign in_series    = s_tdata[62:31];
  assign in_maker_raw = s_tdata[78:63];
  assign key          = s_tdata[109:79];

  // Keep the low MAKER_BITS of the handle, or zero-extend it when MAKER_BITS is wider
  generate
    if (MAKER_BITS <= MAKER_W) begin : g_mk_in_narrow
      assign in_maker = in_maker_raw[MAKER_BITS-1:0];
    end else begin : g_mk_in_wide
      assign in_maker = {{(MAKER_BITS - MAKER_W){1'b0}}, in_maker_raw};
    end
  endgenerate

  logic s_accept;
  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign s_accept = s_tvalid && s_tready;

  // Cell chain
  logic [ID_W-1:0]       cell_id     [DEPTH];
  logic [SERIES_W-1:0]   cell_series [DEPTH];
  logic [MAKER_BITS-1:0] cell_maker  [DEPTH];
  logic                  cell_first  [DEPTH];
  logic [DEPTH:0]        hit;

  assign hit[0] = 1'b0;

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ID_W-1:0]       l_id, r_id;
      logic [SERIES_W-1:0]   l_series, r_series;
      logic [MAKER_BITS-1:0] l_maker, r_maker;

      if (i == 0) begin : g_head
        assign l_id     = in_id;
        assign l_series = in_series;
        assign l_maker  = in_maker;
      end else begin : g_mid
        assign l_id     = cell_id[i-1];
        assign l_series = cell_series[i-1];
        assign l_maker  = cell_maker[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign r_id     = cell_id[i];
        assign r_series = cell_series[i];
        assign r_maker  = cell_maker[i];
      end else begin : g_body
        assign r_id     = cell_id[i+1];
        assign r_series = cell_series[i+1];
        assign r_maker  = cell_maker[i+1];
      end

      ksq_cell #(
        .DEPTH      (DEPTH),
        .INDEX      (i),
        .MAKER_BITS (MAKER_BITS)
      ) u_cell (
        .clk          (clk),
        .ctrl         (ctrl),
        .count        (count),
        .key          (key),
        .in_id        (in_id),
        .in_series    (in_series),
        .in_maker     (in_maker),
        .left_id      (l_id),
        .left_series  (l_series),
        .left_maker   (l_maker),
        .right_id     (r_id),
        .right_series (r_series),
        .right_maker  (r_maker),
        .prefix_in    (hit[i]),
        .hit_out      (hit[i+1]),
        .first        (cell_first[i]),
        .id           (cell_id[i]),
        .series       (cell_series[i]),
        .maker        (cell_maker[i])
      );
    end
  endgenerate

  // Gather the record of the first hit
  logic [ID_W-1:0]       sel_id;
  logic [SERIES_W-1:0]   sel_series;
  logic [MAKER_BITS-1:0] sel_maker;

  always_comb begin
    sel_id     = '0;
    sel_series = '0;
    sel_maker  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_first[i]) begin
        sel_id     = sel_id | cell_id[i];
        sel_series = sel_series | cell_series[i];
        sel_maker  = sel_maker | cell_maker[i];
      end
    end
  end

  // Decode command and form the result
  logic                  out_load;
  logic                  res_found;
  status_t               res_status;
  logic [ID_W-1:0]       res_id;
  logic [SERIES_W-1:0]   res_series;
  logic [MAKER_BITS-1:0] res_maker;

  always_comb begin
    state_next = state;
    count_next = count;
    ctrl.op    = CELL_HOLD;
    out_load   = 1'b0;
    res_found  = 1'b0;
    res_status = ST_OK;
    res_id     = '0;
    res_series = '0;
    res_maker  = '0;
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              out_load = 1'b1;
              if (count == CntW'(DEPTH)) begin
                res_status = ST_FULL;
              end else begin
                ctrl.op    = (cmd == CMD_PUSH_FRONT) ? CELL_SHR : CELL_TAIL;
                count_next = count + 1'b1;
              end
            end
            CMD_POP_FRONT: begin
              out_load = 1'b1;
              if (count == '0) begin
                res_status = ST_NONE;
              end else begin
                ctrl.op    = CELL_SHL;
                count_next = count - 1'b1;
                res_found  = 1'b1;
                res_id     = cell_id[0];
                res_series = cell_series[0];
                res_maker  = cell_maker[0];
              end
            end
            CMD_EXTRACT: begin
              ctrl.op    = CELL_CMP;
              state_next = S_SEARCH;
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        out_load   = 1'b1;
        ctrl.op    = CELL_EXTRACT;
        state_next = S_IDLE;
        if (hit[DEPTH]) begin
          count_next = count - 1'b1;
          res_found  = 1'b1;
          res_id     = sel_id;
          res_series = sel_series;
          res_maker  = sel_maker;
        end else begin
          res_status = ST_NONE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Fit handle and fill count to their port widths
  logic [MAKER_W-1:0] res_maker_out;
  logic [FILL_W-1:0]  fill_out;

  generate
    if (MAKER_BITS <= MAKER_W) begin : g_mk_out_narrow
      assign res_maker_out = MAKER_W'(res_maker);
    end else begin : g_mk_out_wide
      assign res_maker_out = res_maker[MAKER_W-1:0];
    end
    if (CntW <= FILL_W) begin : g_fill_narrow
      assign fill_out = FILL_W'(count_next);
    end else begin : g_fill_wide
      assign fill_out = count_next[FILL_W-1:0];
    end
  endgenerate

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'b0, fill_out, res_maker_out, res_series, res_id};
      m_tuser <= {res_status, res_found};
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("fill count above depth");

  a_search_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> !s_tready)
    else $error("input taken during extract search");

  a_extract_enters_search: assert property (@(posedge clk) disable iff (rst)
    (s_accept && cmd == CMD_EXTRACT) |=> (state == S_SEARCH))
    else $error("extract did not start search");

  a_search_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |=> m_tvalid)
    else $error("search finished without result");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == ST_OK))
    else $error("found result with error status");

endmodule

>>> hdl/ksq_cell.sv
// One slot of the record chain: holds a record and trades it with its neighbors.
module ksq_cell #(
  parameter int DEPTH      = ksq_pkg::DEPTH_DEF,
  parameter int INDEX      = 0,
  parameter int MAKER_BITS = ksq_pkg::MAKER_BITS_DEF,
  localparam int CntW      = $clog2(DEPTH + 1)
) (
  input  logic                           clk,
  input  ksq_pkg::cell_ctrl_t            ctrl,
  input  logic [CntW-1:0]                count,
  input  logic [ksq_pkg::ID_W-1:0]       key,
  input  logic [ksq_pkg::ID_W-1:0]       in_id,
  input  logic [ksq_pkg::SERIES_W-1:0]   in_series,
  input  logic [MAKER_BITS-1:0]          in_maker,
  input  logic [ksq_pkg::ID_W-1:0]       left_id,
  input  logic [ksq_pkg::SERIES_W-1:0]   left_series,
  input  logic [MAKER_BITS-1:0]          left_maker,
  input  logic [ksq_pkg::ID_W-1:0]       right_id,
  input  logic [ksq_pkg::SERIES_W-1:0]   right_series,
  input  logic [MAKER_BITS-1:0]          right_maker,
  input  logic                           prefix_in,
  output logic                           hit_out,
  output logic                           first,
  output logic [ksq_pkg::ID_W-1:0]       id,
  output logic [ksq_pkg::SERIES_W-1:0]   series,
  output logic [MAKER_BITS-1:0]          maker
);
  import ksq_pkg::*;

  logic match;
  logic occupied;
  logic at_tail;

  assign occupied = CntW'(INDEX) < count;
  assign at_tail  = CntW'(INDEX) == count;

  // Pass the first-hit mark down the chain
  assign hit_out = prefix_in | match;
  assign first   = match & ~prefix_in;

  // Shift, load or compare as the broadcast operation says
  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_SHR: begin
        id     <= left_id;
        series <= left_series;
        maker  <= left_maker;
      end
      CELL_TAIL: begin
        if (at_tail) begin
          id     <= in_id;
          series <= in_series;
          maker  <= in_maker;
        end
      end
      CELL_SHL: begin
        id     <= right_id;
        series <= right_series;
        maker  <= right_maker;
      end
      CELL_CMP: begin
        match <= occupied && (id == key);
      end
      CELL_EXTRACT: begin
        if (hit_out) begin
          id     <= right_id;
          series <= right_series;
          maker  <= right_maker;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
